FILE: design/rrts_pkg.sv
// Shared types and codes for the round-robin thread scheduler.
`timescale 1ns / 1ps
`default_nettype none

package rrts_pkg;

    localparam int TID_W = 5;

    localparam logic [2:0] ACT_ADD      = 3'd0;
    localparam logic [2:0] ACT_REMOVE   = 3'd1;
    localparam logic [2:0] ACT_BLOCK    = 3'd2;
    localparam logic [2:0] ACT_UNBLOCK  = 3'd3;
    localparam logic [2:0] ACT_YIELD    = 3'd4;
    localparam logic [2:0] ACT_SCHEDULE = 3'd5;

    localparam logic [1:0] KIND_WAITING = 2'd1;
    localparam logic [1:0] KIND_HANGING = 2'd2;

    localparam logic [1:0] RC_OK        = 2'd0;
    localparam logic [1:0] RC_FULL      = 2'd1;
    localparam logic [1:0] RC_NOT_FOUND = 2'd2;

    typedef enum logic [2:0] {
        SS_READY   = 3'd0,
        SS_RUNNING = 3'd1,
        SS_BLOCKED = 3'd2,
        SS_WAITING = 3'd3,
        SS_HANGING = 3'd4
    } slot_state_t;

    typedef enum logic [2:0] {
        CELL_HOLD    = 3'd0,
        CELL_ADD     = 3'd1,
        CELL_REMOVE  = 3'd2,
        CELL_BLOCK   = 3'd3,
        CELL_DEMOTE  = 3'd4,
        CELL_UNBLOCK = 3'd5,
        CELL_WAKE    = 3'd6,
        CELL_PICK    = 3'd7
    } cell_op_t;

    typedef struct packed {
        logic [2:0]       action;
        logic [TID_W-1:0] thread_id;
        logic [1:0]       block_kind;
    } req_t;

    typedef struct packed {
        logic [TID_W-1:0] running_id;
        logic             running_valid;
        logic [1:0]       result_code;
        logic [5:0]       entry_count;
    } rsp_t;

    typedef struct packed {
        cell_op_t         op;
        logic [TID_W-1:0] key;
        slot_state_t      blk_state;
        logic             pick_hi;
    } cell_cmd_t;

    typedef struct packed {
        logic seen;
        logic hi;
        logic lo;
    } cell_chain_t;

    typedef struct packed {
        logic             ready;
        logic             hit;
        logic             win;
        logic             below_cur;
        logic             sel_running;
        logic [TID_W-1:0] sel_thread;
    } cell_stat_t;

endpackage

`default_nettype wire

FILE: design/round_robin_thread_scheduler.sv
// Top level of the round-robin thread scheduler: control sequencer and row of slot cells.
//
// Requests enter on req_valid / req_stall / req_data (action, thread_id, block_kind);
// one response per request leaves on rsp_valid / rsp_stall / rsp_data with the
// running thread, result code and list length. A transfer happens on a rising edge
// where valid is high and stall is low.
// idle_id is written through cfg_wr_en / cfg_wr_data; the user must write it only while
// no request is in flight, as the block itself has no check for it. Each request passes
// four sequencer steps: apply (add, compaction shift, status write), idle wake,
// next-ready pick, and response load, where the response is registered. A new request
// is taken only in the idle state or in the response-load step, never earlier. Each
// slot is a cell; the find-first and compaction searches ripple once along the cell
// row per step. Reset empties the list, sets the current position and idle_id to zero
// and drops any pending response; no clearing pass is needed.
// While rsp_stall holds a response, the finished request waits in the load step
// and req_stall stays high; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_thread_scheduler
    import rrts_pkg::*;
#(
    parameter int MAX_SLOTS = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire req_t             req_data,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output rsp_t                  rsp_data,
    input  wire logic             cfg_wr_en,
    input  wire logic [TID_W-1:0] cfg_wr_data
);

    localparam int LEN_W = $clog2(MAX_SLOTS + 1);
    localparam int IDX_W = $clog2(MAX_SLOTS);

    typedef enum logic [4:0] {
        FSM_IDLE  = 5'b00001,
        FSM_APPLY = 5'b00010,
        FSM_WAKE  = 5'b00100,
        FSM_PICK  = 5'b01000,
        FSM_DONE  = 5'b10000
    } fsm_t;

    fsm_t             fsm_reg, fsm_next;
    req_t             req_reg, req_next;
    rsp_t             rsp_reg, rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [1:0]       code_reg, code_next;
    logic [TID_W-1:0] idle_reg;

    cell_cmd_t        cmd;
    cell_chain_t      chain [MAX_SLOTS+1];
    cell_stat_t       stat [MAX_SLOTS];
    logic [TID_W-1:0] thread_vec [MAX_SLOTS];
    slot_state_t      state_vec [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] win_vec;

    logic             accept;
    logic             rsp_free;
    logic             is_sched;
    logic             any_ready;
    logic             any_hit;
    logic             any_win;
    logic             any_below;
    logic             any_running;
    logic [TID_W-1:0] running_thread;
    logic [IDX_W-1:0] win_idx;
    slot_state_t      blk_state;

    assign chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_SLOTS; g++)
        begin : g_cell
            rrts_cell #(
                .SLOT_IDX (g),
                .LEN_W    (LEN_W),
                .IDX_W    (IDX_W)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .len        (len_reg),
                .cur        (cur_reg),
                .nbr_thread (thread_vec[(g + 1 < MAX_SLOTS) ? g + 1 : g]),
                .nbr_state  (state_vec[(g + 1 < MAX_SLOTS) ? g + 1 : g]),
                .chain_in   (chain[g]),
                .chain_out  (chain[g+1]),
                .thread     (thread_vec[g]),
                .status     (state_vec[g]),
                .stat       (stat[g])
            );
            assign win_vec[g] = stat[g].win;
        end
    endgenerate

    always_comb
    begin
        any_ready      = 1'b0;
        any_hit        = 1'b0;
        any_below      = 1'b0;
        any_running    = 1'b0;
        running_thread = '0;
        win_idx        = '0;
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            any_ready = any_ready | stat[i].ready;
            any_hit   = any_hit | stat[i].hit;
            any_below = any_below | stat[i].below_cur;
            if (stat[i].sel_running)
            begin
                any_running    = 1'b1;
                running_thread = running_thread | stat[i].sel_thread;
            end
            if (stat[i].win)
                win_idx = win_idx | IDX_W'(i);
        end
    end

    assign any_win   = |win_vec;
    assign accept    = req_valid && !req_stall;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !((fsm_reg == FSM_IDLE) || (fsm_reg == FSM_DONE && rsp_free));
    assign is_sched  = req_reg.action inside {ACT_BLOCK, ACT_YIELD, ACT_SCHEDULE};

    always_comb
    begin
        case (req_reg.block_kind)
            KIND_WAITING: blk_state = SS_WAITING;
            KIND_HANGING: blk_state = SS_HANGING;
            default:      blk_state = SS_BLOCKED;
        endcase
    end

    always_comb
    begin
        fsm_next       = fsm_reg;
        req_next       = req_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        len_next       = len_reg;
        cur_next       = cur_reg;
        code_next      = code_reg;
        cmd.op         = CELL_HOLD;
        cmd.key        = req_reg.thread_id;
        cmd.blk_state  = blk_state;
        cmd.pick_hi    = chain[MAX_SLOTS].hi;

        case (fsm_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    req_next  = req_data;
                    code_next = RC_OK;
                    fsm_next  = FSM_APPLY;
                end
            end
            FSM_APPLY:
            begin
                case (req_reg.action)
                    ACT_ADD:
                    begin
                        if (len_reg >= LEN_W'(MAX_SLOTS))
                            code_next = RC_FULL;
                        else
                        begin
                            cmd.op   = CELL_ADD;
                            len_next = len_reg + LEN_W'(1);
                        end
                    end
                    ACT_REMOVE:
                    begin
                        cmd.op = CELL_REMOVE;
                        if (!chain[MAX_SLOTS].seen)
                            code_next = RC_NOT_FOUND;
                        else
                        begin
                            len_next = len_reg - LEN_W'(1);
                            if (any_below)
                                cur_next = cur_reg - IDX_W'(1);
                        end
                    end
                    ACT_BLOCK:
                    begin
                        cmd.op = CELL_BLOCK;
                    end
                    ACT_UNBLOCK:
                    begin
                        cmd.op = CELL_UNBLOCK;
                        if (!any_hit)
                            code_next = RC_NOT_FOUND;
                    end
                    ACT_YIELD, ACT_SCHEDULE:
                    begin
                        cmd.op = CELL_DEMOTE;
                    end
                    default:
                    begin
                        cmd.op = CELL_HOLD;
                    end
                endcase
                fsm_next = FSM_WAKE;
            end
            FSM_WAKE:
            begin
                cmd.key = idle_reg;
                if (is_sched && !any_ready)
                    cmd.op = CELL_WAKE;
                fsm_next = FSM_PICK;
            end
            FSM_PICK:
            begin
                if (is_sched)
                begin
                    cmd.op = CELL_PICK;
                    if (any_win)
                        cur_next = win_idx;
                end
                fsm_next = FSM_DONE;
            end
            FSM_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_next.running_id    = any_running ? running_thread : '0;
                    rsp_next.running_valid = any_running;
                    rsp_next.result_code   = code_reg;
                    rsp_next.entry_count   = 6'(len_reg);
                    if (accept)
                    begin
                        req_next  = req_data;
                        code_next = RC_OK;
                        fsm_next  = FSM_APPLY;
                    end
                    else
                        fsm_next = FSM_IDLE;
                end
            end
            default:
            begin
                fsm_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= FSM_IDLE;
            rsp_valid_reg <= 1'b0;
            len_reg       <= '0;
            cur_reg       <= '0;
            idle_reg      <= '0;
        end
        else
        begin
            fsm_reg       <= fsm_next;
            rsp_valid_reg <= rsp_valid_next;
            len_reg       <= len_next;
            cur_reg       <= cur_next;
            if (cfg_wr_en)
                idle_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        rsp_reg  <= rsp_next;
        code_reg <= code_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_SLOTS))
        else $error("list length beyond slot count");

    a_single_winner: assert property (@(posedge clk) disable iff (!rst_n)
        fsm_reg == FSM_PICK |-> $onehot0(win_vec))
        else $error("more than one slot picked");

    a_accept_apply: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> fsm_reg == FSM_APPLY)
        else $error("accepted request not applied");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_reg == FSM_DONE && rsp_free) |=> rsp_valid_reg)
        else $error("finished request not loaded into response");

    a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
        fsm_reg != FSM_APPLY |=> len_reg == $past(len_reg))
        else $error("list length changed outside apply step");

endmodule

`default_nettype wire

FILE: design/rrts_cell.sv
// One list slot: thread id, status, and its links in the search chains.
`timescale 1ns / 1ps
`default_nettype none

module rrts_cell
    import rrts_pkg::*;
#(
    parameter int SLOT_IDX = 0,
    parameter int LEN_W    = 6,
    parameter int IDX_W    = 5
) (
    input  wire logic              clk,
    input  wire cell_cmd_t         cmd,
    input  wire logic [LEN_W-1:0]  len,
    input  wire logic [IDX_W-1:0]  cur,
    input  wire logic [TID_W-1:0]  nbr_thread,
    input  wire slot_state_t       nbr_state,
    input  wire cell_chain_t       chain_in,
    output cell_chain_t            chain_out,
    output logic [TID_W-1:0]       thread,
    output slot_state_t            status,
    output cell_stat_t             stat
);

    logic [TID_W-1:0] thread_reg, thread_next;
    slot_state_t      state_reg, state_next;
    logic             in_list;
    logic             is_cur;
    logic             is_tail;
    logic             above_cur;
    logic             ready;
    logic             hit;
    logic             win;

    assign in_list   = LEN_W'(SLOT_IDX) < len;
    assign is_tail   = LEN_W'(SLOT_IDX) == len;
    assign is_cur    = IDX_W'(SLOT_IDX) == cur;
    assign above_cur = IDX_W'(SLOT_IDX) > cur;
    assign ready     = in_list && (state_reg == SS_READY);
    assign hit       = in_list && (thread_reg == cmd.key);

    assign chain_out.seen = chain_in.seen | hit;
    assign chain_out.hi   = chain_in.hi | (ready & above_cur);
    assign chain_out.lo   = chain_in.lo | ready;

    assign win = cmd.pick_hi ? (ready && above_cur && !chain_in.hi)
                             : (ready && !chain_in.lo);

    assign stat.ready       = ready;
    assign stat.hit         = hit;
    assign stat.win         = win;
    assign stat.below_cur   = is_cur & chain_in.seen;
    assign stat.sel_running = is_cur && in_list && (state_reg == SS_RUNNING);
    assign stat.sel_thread  = thread_reg;

    assign thread = thread_reg;
    assign status = state_reg;

    always_comb
    begin
        thread_next = thread_reg;
        state_next  = state_reg;
        case (cmd.op)
            CELL_ADD:
            begin
                if (is_tail)
                begin
                    thread_next = cmd.key;
                    state_next  = SS_READY;
                end
            end
            CELL_REMOVE:
            begin
                if (chain_out.seen)
                begin
                    thread_next = nbr_thread;
                    state_next  = nbr_state;
                end
            end
            CELL_BLOCK:
            begin
                if (is_cur && in_list)
                    state_next = cmd.blk_state;
            end
            CELL_DEMOTE:
            begin
                if (is_cur && in_list && state_reg == SS_RUNNING)
                    state_next = SS_READY;
            end
            CELL_UNBLOCK, CELL_WAKE:
            begin
                if (hit)
                    state_next = SS_READY;
            end
            CELL_PICK:
            begin
                if (win)
                    state_next = SS_RUNNING;
            end
            default:
            begin
                thread_next = thread_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        thread_reg <= thread_next;
        state_reg  <= state_next;
    end

endmodule

`default_nettype wire
